[rtl/arxp_pkg.sv]
// Shared types, round tables and the rotate helper for the 512-bit ARX permutation.
package arxp_pkg;

	localparam int unsigned WORD_W    = 64;
	localparam int unsigned NUM_WORDS = 8;
	localparam int unsigned TABLE_LEN = 16;
	localparam int unsigned STATE_W   = WORD_W * NUM_WORDS;

	typedef logic [WORD_W-1:0] word_t;
	typedef word_t [NUM_WORDS-1:0] state_t;

	localparam word_t RC [TABLE_LEN] = '{
		64'h313c6532d658201a, 64'h956d549917eac3c0,
		64'h083d4edaf496ee20, 64'h0cb386eeab6965d2,
		64'h6f856ac36b7642e0, 64'he81887430eb2f988,
		64'haed89bd9076d6e8b, 64'habe63903dd74dfbb,
		64'h1add4c445f6c7432, 64'hd1d113667136bbcc,
		64'hcbf0b33854f1a287, 64'h37e6e010269e7e78,
		64'h9856a37486c20a3c, 64'h5020a4e865c9be36,
		64'h1401db7b7dac82b8, 64'h62cdab713371b069
	};

	localparam int unsigned SH_A [TABLE_LEN] = '{
		49,  1,  9, 13, 41, 59, 21, 23, 39,  5, 45,  3, 51, 63, 11, 57
	};
	localparam int unsigned SH_B [TABLE_LEN] = '{
		43, 11, 41, 25, 51, 47, 35,  3, 21, 63,  9, 45, 49, 17, 55, 19
	};
	localparam int unsigned SH_C [TABLE_LEN] = '{
		49, 63, 39, 61, 45, 37, 27, 41, 53, 21, 59, 55, 35, 33, 19, 29
	};
	localparam int unsigned SH_D [TABLE_LEN] = '{
		11, 45, 59, 41, 33, 17, 49, 39, 15,  5, 27, 51, 57, 53, 47,  1
	};

	function automatic word_t rotl(word_t v, int unsigned n);
		logic [5:0] k;
		k = n[5:0];
		return (v << k) | (v >> (WORD_W - k));
	endfunction

endpackage

[rtl/arxp_cell.sv]
// One round of the permutation as a two-stage cell of the round chain.
module arxp_cell import arxp_pkg::*; #(
	parameter int unsigned ROUND = 0
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  logic   in_valid,
	input  state_t in_w,
	output logic   out_valid,
	output state_t out_w
);

	localparam int unsigned T  = ROUND % TABLE_LEN;
	localparam int unsigned CI = (3 * ROUND) % NUM_WORDS;
	localparam int unsigned R1 = (3 * ROUND + 7) % WORD_W;
	localparam int unsigned R2 = (5 * ROUND + 23) % WORD_W;
	localparam int unsigned R3 = (7 * ROUND + 41) % WORD_W;
	localparam int unsigned O1 = (2 * ROUND + 1) % NUM_WORDS;
	localparam int unsigned O2 = (3 * ROUND + 3) % NUM_WORDS;

	state_t mid_c;
	state_t mid_s1;
	logic   v_s1;
	state_t nxt_c;
	state_t w_s2;
	logic   v_s2;

	// first half of each box: constant, add, xor
	always_comb begin
		logic [2:0] a;
		logic [2:0] b;
		word_t      x;
		word_t      y;
		mid_c = in_w;
		mid_c[CI] = in_w[CI] ^ RC[T];
		for (int i = 0; i < 4; i++) begin
			a = 3'((2 * i + ROUND) % NUM_WORDS);
			b = a + 3'd1;
			x = mid_c[a] + rotl(mid_c[b], SH_A[T]);
			y = mid_c[b] ^ rotl(x, SH_B[T]);
			mid_c[a] = x;
			mid_c[b] = y;
		end
	end

	// second half of each box, then diffusion and word mixing
	always_comb begin
		logic [2:0] a;
		logic [2:0] b;
		word_t      x;
		word_t      y;
		state_t     st;
		state_t     u;
		st = mid_s1;
		for (int i = 0; i < 4; i++) begin
			a = 3'((2 * i + ROUND) % NUM_WORDS);
			b = a + 3'd1;
			x = st[a] + rotl(st[b], SH_C[T]);
			y = st[b] ^ rotl(x, SH_D[T]);
			st[a] = x;
			st[b] = y;
		end
		for (int i = 0; i < NUM_WORDS; i++) begin
			u[i] = st[i] ^ rotl(st[i], R1) ^ rotl(st[i], R2) ^ rotl(st[i], R3);
		end
		for (int i = 0; i < NUM_WORDS; i++) begin
			nxt_c[i] = u[i] ^ u[3'((i + O1) % NUM_WORDS)] ^ u[3'((i + O2) % NUM_WORDS)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mid_s1 <= mid_c;
			w_s2   <= nxt_c;
		end
	end

	assign out_valid = v_s2;
	assign out_w     = w_s2;

endmodule

[rtl/arxp_out_buf.sv]
// Two-entry output buffer that decouples the round chain from the receiver.
module arxp_out_buf import arxp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  state_t in_data,
	output logic   out_valid,
	input  logic   out_ready,
	output state_t out_data
);

	localparam logic [1:0] CNT_EMPTY = 2'd0;
	localparam logic [1:0] CNT_ONE   = 2'd1;
	localparam logic [1:0] CNT_FULL  = 2'd2;

	logic [1:0] cnt_q;
	state_t     head_q;
	state_t     spare_q;
	logic       push;
	logic       pop;

	assign in_ready  = (cnt_q != CNT_FULL);
	assign out_valid = (cnt_q != CNT_EMPTY);
	assign out_data  = head_q;
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= CNT_EMPTY;
		end else begin
			cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, pop});
		end
	end

	always_ff @(posedge clk) begin
		if (pop && cnt_q == CNT_FULL) begin
			head_q <= spare_q;
		end else if (push && (cnt_q == CNT_EMPTY || pop)) begin
			head_q <= in_data;
		end
		if (push && cnt_q == CNT_ONE && !pop) begin
			spare_q <= in_data;
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == CNT_FULL |-> !push)
		else $error("beat pushed into full output buffer");

	a_full_pop_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == CNT_FULL && pop |=> out_valid && cnt_q == CNT_ONE)
		else $error("spare beat lost after pop");

	a_drain_one: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == CNT_ONE && pop && !push |=> !out_valid)
		else $error("output valid without stored beat");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output buffer count out of range");

endmodule

[rtl/arx_permutation_512.sv]
// Top level of the 512-bit ARX permutation: round cell chain and output buffer.
//
// Input beats arrive on s_tvalid/s_tready/s_tdata; s_tdata carries the eight
// 64-bit state words, word 0 in the lowest bits. Each beat yields exactly one
// output beat on m_tvalid/m_tready/m_tdata, same packing, in input order.
//
// The state runs through NUM_ROUNDS cells, each one round in two register
// stages (one 64-bit add level per stage); an accepted beat passes both stage
// registers of each cell in turn, then the output buffer, to reach m_tvalid.
// A new beat is taken every cycle while the receiver keeps up.
//
// The chain feeds a two-entry output buffer; s_tready is high whenever that
// buffer is not full, so a stalled receiver holds one finished beat and the
// chain still moves one more. When the buffer fills, the whole chain and
// s_tready hold until the receiver takes a beat.
//
// Reset clears every valid bit and the buffer; no beat is in flight after
// reset. Data registers are not reset.
module arx_permutation_512 import arxp_pkg::*; #(
	parameter int unsigned NUM_ROUNDS = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [STATE_W-1:0] s_tdata,  // in_word0 .. in_word7, 64 bits each
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [STATE_W-1:0] m_tdata   // out_word0 .. out_word7, 64 bits each
);

	state_t chain_w [NUM_ROUNDS+1];
	logic   chain_v [NUM_ROUNDS+1];
	logic   adv;
	state_t out_w;

	assign chain_w[0] = state_t'(s_tdata);
	assign chain_v[0] = s_tvalid;
	assign s_tready   = adv;

	for (genvar r = 0; r < NUM_ROUNDS; r++) begin : g_round
		arxp_cell #(
			.ROUND(r)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.in_valid (chain_v[r]),
			.in_w     (chain_w[r]),
			.out_valid(chain_v[r+1]),
			.out_w    (chain_w[r+1])
		);
	end

	arxp_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (chain_v[NUM_ROUNDS]),
		.in_ready (adv),
		.in_data  (chain_w[NUM_ROUNDS]),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data (out_w)
	);

	assign m_tdata = STATE_W'(out_w);

endmodule

[bench/permutation_checker.sv]
// Checker for the 512-bit ARX permutation: predicts each output beat and compares it.
`timescale 1ns / 1ps

module permutation_checker import arxp_pkg::*; #(
	parameter int unsigned NUM_ROUNDS = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	input  logic               s_tready,
	input  logic [STATE_W-1:0] s_tdata,  // in_word0 .. in_word7, 64 bits each
	input  logic               m_tvalid,
	input  logic               m_tready,
	input  logic [STATE_W-1:0] m_tdata,  // out_word0 .. out_word7, 64 bits each
	output int unsigned        mismatches,
	output int unsigned        in_flight
);

	state_t expected_states[$];

	initial begin
		mismatches = 0;
		in_flight  = 0;
	end

	function automatic word_t rotate_word(word_t v, int unsigned amount);
		int unsigned k;
		k = amount % WORD_W;
		if (k == 0)
			return v;
		return (v << k) | (v >> (WORD_W - k));
	endfunction

	function automatic state_t permute_state(state_t st);
		state_t      w;
		state_t      mixed;
		word_t       x;
		word_t       y;
		word_t       v;
		int unsigned t;
		int unsigned a;
		int unsigned b;
		int unsigned o1;
		int unsigned o2;
		w = st;
		for (int unsigned r = 0; r < NUM_ROUNDS; r++) begin
			t = r % TABLE_LEN;
			w[(3 * r) % NUM_WORDS] ^= RC[t];
			for (int unsigned i = 0; i < 4; i++) begin
				a = (2 * i + r) % NUM_WORDS;
				b = (a + 1) % NUM_WORDS;
				x = w[a];
				y = w[b];
				x = x + rotate_word(y, SH_A[t]);
				y = y ^ rotate_word(x, SH_B[t]);
				x = x + rotate_word(y, SH_C[t]);
				y = y ^ rotate_word(x, SH_D[t]);
				w[a] = x;
				w[b] = y;
			end
			for (int unsigned i = 0; i < NUM_WORDS; i++) begin
				v = w[i];
				w[i] = v ^ rotate_word(v, 3 * r + 7) ^ rotate_word(v, 5 * r + 23)
					^ rotate_word(v, 7 * r + 41);
			end
			o1 = (2 * r + 1) % NUM_WORDS;
			o2 = (3 * r + 3) % NUM_WORDS;
			for (int unsigned i = 0; i < NUM_WORDS; i++)
				mixed[i] = w[i] ^ w[(i + o1) % NUM_WORDS] ^ w[(i + o2) % NUM_WORDS];
			w = mixed;
		end
		return w;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatches < 40)
			$display("%0t ns: %s", $time, msg);
		mismatches++;
	endtask

	always @(posedge clk) begin
		state_t got;
		state_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				expected_states.push_back(permute_state(state_t'(s_tdata)));
			if (m_tvalid && m_tready) begin
				got = state_t'(m_tdata);
				if (expected_states.size() == 0) begin
					report_mismatch($sformatf("unexpected output beat %h", got));
				end else begin
					want = expected_states.pop_front();
					for (int i = 0; i < NUM_WORDS; i++)
						if (got[i] !== want[i])
							report_mismatch($sformatf("out_word%0d: got %h, want %h",
								i, got[i], want[i]));
				end
			end
			in_flight <= expected_states.size();
		end
	end

endmodule

[bench/tb.sv]
// Top of the ARX permutation bench: clock, reset, beat traffic and the verdict.
`timescale 1ns / 1ps

module tb;
	import arxp_pkg::*;

	localparam int unsigned ROUNDS         = 4;
	localparam int unsigned RANDOM_BEATS   = 935;
	localparam int unsigned QUIET_TAIL     = 150;
	localparam int unsigned WATCHDOG_LIMIT = 2000;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [STATE_W-1:0] s_tdata;   // in_word0 .. in_word7, 64 bits each
	logic               m_tvalid;
	logic               m_tready;
	logic [STATE_W-1:0] m_tdata;   // out_word0 .. out_word7, 64 bits each

	int unsigned mismatches;
	int unsigned in_flight;
	int unsigned idle_cycles = 0;
	bit          quiet = 1'b0;
	bit          hold_request = 1'b0;

	arx_permutation_512 #(.NUM_ROUNDS(ROUNDS)) uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	permutation_checker #(.NUM_ROUNDS(ROUNDS)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.mismatches(mismatches), .in_flight(in_flight)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("arx_permutation_512: mismatch");
			$finish;
		end
	end

	function automatic word_t random_word();
		word_t v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0: v = '0;
			1: v = '1;
			2: v = word_t'(1) << $urandom_range(0, 63);
			3: v = ~(word_t'(1) << $urandom_range(0, 63));
			4: v = v & {$urandom, $urandom} & {$urandom, $urandom};
			5: v = v | {$urandom, $urandom} | {$urandom, $urandom};
			default: ;
		endcase
		return v;
	endfunction

	task automatic send_beat(input state_t st);
		s_tdata  <= st;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (in_flight == 0);
		@(posedge clk);
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		m_tready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				m_tready <= 1'b0;
				repeat (120) @(posedge clk);
				hold_request = 1'b0;
			end
			if (!quiet && $urandom_range(0, 2) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 40)) @(posedge clk);
		end
	end

	initial begin
		state_t st;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_beat('0);
		send_beat('1);
		for (int i = 0; i < NUM_WORDS; i++) begin
			st = '0;
			st[i] = '1;
			send_beat(st);
		end
		send_beat({NUM_WORDS{64'h5555_5555_5555_5555}});
		send_beat({NUM_WORDS{64'haaaa_aaaa_aaaa_aaaa}});
		send_beat({NUM_WORDS{64'h0000_0000_0000_0001}});
		send_beat({NUM_WORDS{64'h8000_0000_0000_0000}});
		st = '1;
		st[3] = '0;
		send_beat(st);
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < NUM_WORDS; j++)
				st[j] = random_word();
			send_beat(st);
		end
		drain();

		for (int n = 0; n < RANDOM_BEATS; n++) begin
			quiet = (n >= RANDOM_BEATS - QUIET_TAIL);
			if (n == 300)
				hold_request = 1'b1;
			if (n == 600)
				drain();
			for (int j = 0; j < NUM_WORDS; j++)
				st[j] = random_word();
			send_beat(st);
		end
		drain();
		repeat (2 * ROUNDS + 4) @(posedge clk);

		if (mismatches == 0)
			$display("arx_permutation_512: match");
		else
			$display("arx_permutation_512: mismatch");
		$finish;
	end

endmodule
